// File: sv/vtpm_pkg.sv
// Package for the version tag pattern matcher: default sizes, register
// indexes, character codes and the per-pattern result type.
// Depends on nothing; every other file refers to it by scoped names.
package vtpm_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_PATTERNS_DEF  = 2;
	localparam int PATTERN_BYTES_DEF = 16;
	localparam int MAX_RECORD_DEF    = 255;

	// Only the first two patterns have registers behind them
	localparam int NUM_REG_PATTERNS = 2;
	localparam int PAT_BITS         = 128;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LOW       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HIGH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HIGH     = 3'd4;

	// Character codes
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_VCHAR_LO = 8'h21;
	localparam logic [7:0] CH_VCHAR_HI = 8'h7E;
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_LOWER_V  = 8'h76;
	localparam logic [7:0] CH_LOWER_D  = 8'h64;
	localparam logic [7:0] CH_DIGIT_0  = 8'h30;
	localparam logic [7:0] CH_DIGIT_9  = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_DELTA  = 8'h20;

	// Outcome of one pattern for the record that ends with the current byte
	typedef struct packed {
		logic       matched;
		logic [7:0] match_end;
	} lane_res_t;

endpackage

// File: sv/vtpm_lane.sv
// One pattern lane of the version tag pattern matcher: holds the match
// state of one pattern and advances it by one record byte per step.
// Depends on vtpm_pkg.
module vtpm_lane #(
	parameter int PATTERN_BYTES = vtpm_pkg::PATTERN_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           last,
	input  logic [7:0]                     text_byte,
	input  logic [7:0]                     end_off,
	input  logic [vtpm_pkg::PAT_BITS-1:0]  pattern,
	output vtpm_pkg::lane_res_t            res
);

	localparam int PB_EFF = (PATTERN_BYTES < 16) ? PATTERN_BYTES : 16;
	localparam int POS_W  = $clog2(PATTERN_BYTES + 3);
	localparam int NPOS   = 1 << POS_W;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_MATCH = 2'd1,
		ST_FAIL  = 2'd2
	} status_t;

	logic [POS_W-1:0] pos_q, pos_n;
	logic             run_q, run_n;
	status_t          status_q, status_n, status_fin;
	logic [7:0]       end_q, end_n;

	logic [7:0] lc;
	logic       is_vc, is_dg, is_sp, is_cm, is_pc;

	logic [NPOS-1:0] is_pv, fin_ok, dig_prev, adv1, adv2, set_run, hit;
	logic [POS_W-1:0] q;
	logic             run_keep;

	assign is_vc = (text_byte >= vtpm_pkg::CH_VCHAR_LO) && (text_byte <= vtpm_pkg::CH_VCHAR_HI);
	assign is_dg = (text_byte >= vtpm_pkg::CH_DIGIT_0) && (text_byte <= vtpm_pkg::CH_DIGIT_9);
	assign is_sp = (text_byte == vtpm_pkg::CH_SPACE);
	assign is_cm = (text_byte == vtpm_pkg::CH_COMMA);
	assign is_pc = (text_byte == vtpm_pkg::CH_PERCENT);
	assign lc    = ((text_byte >= vtpm_pkg::CH_UPPER_A) && (text_byte <= vtpm_pkg::CH_UPPER_Z))
	               ? text_byte + vtpm_pkg::CASE_DELTA : text_byte;

	// Decode every pattern position against the current byte in parallel
	for (genvar k = 0; k < NPOS; k++) begin : g_pos
		logic [7:0] cur, nx, pv;
		if (k < PB_EFF) begin : g_cur
			assign cur = pattern[8*k +: 8];
		end else begin : g_cur_zero
			assign cur = vtpm_pkg::CH_NUL;
		end
		if (k + 1 < PB_EFF) begin : g_nx
			assign nx = pattern[8*(k+1) +: 8];
		end else begin : g_nx_zero
			assign nx = vtpm_pkg::CH_NUL;
		end
		if (k > 0 && k - 1 < PB_EFF) begin : g_pv
			assign pv = pattern[8*(k-1) +: 8];
		end else begin : g_pv_zero
			assign pv = vtpm_pkg::CH_NUL;
		end

		assign is_pv[k]    = (cur == vtpm_pkg::CH_PERCENT) && (nx == vtpm_pkg::CH_LOWER_V);
		assign fin_ok[k]   = (cur == vtpm_pkg::CH_NUL) ||
		                     ((cur == vtpm_pkg::CH_PERCENT) && (nx == vtpm_pkg::CH_COMMA));
		assign dig_prev[k] = (pv == vtpm_pkg::CH_LOWER_D);
		assign set_run[k]  = is_pv[k] || ((cur == vtpm_pkg::CH_PERCENT) &&
		                     (nx == vtpm_pkg::CH_LOWER_D) && is_dg);
		assign adv2[k]     = set_run[k] || ((cur == vtpm_pkg::CH_PERCENT) &&
		                     (((nx == vtpm_pkg::CH_PERCENT) && is_pc) ||
		                      ((nx == vtpm_pkg::CH_COMMA) && is_cm)));
		assign adv1[k]     = (cur != vtpm_pkg::CH_NUL) && (cur != vtpm_pkg::CH_PERCENT) &&
		                     (lc == cur);
		assign hit[k]      = is_sp && ((cur == vtpm_pkg::CH_NUL) ||
		                     ((cur == vtpm_pkg::CH_PERCENT) && (nx == vtpm_pkg::CH_COMMA)));
	end

	assign run_keep = run_q && (dig_prev[pos_q] ? is_dg : is_vc);

	// A non-printable byte passes over any chain of empty %v runs
	always_comb begin
		q = pos_q;
		if (!is_vc) begin
			for (int j = NPOS - 1; j >= 0; j--) begin
				if (j >= int'(pos_q) && j[0] == pos_q[0] && !is_pv[j])
					q = POS_W'(j);
			end
		end
	end

	always_comb begin
		pos_n    = pos_q;
		run_n    = run_q;
		status_n = status_q;
		end_n    = end_q;
		if (status_q == ST_RUN && !run_keep) begin
			run_n = 1'b0;
			if (hit[q]) begin
				status_n = ST_MATCH;
				end_n    = end_off;
			end else if (adv2[q]) begin
				pos_n = q + POS_W'(2);
				run_n = set_run[q];
			end else if (adv1[q]) begin
				pos_n = q + POS_W'(1);
			end else begin
				status_n = ST_FAIL;
			end
		end
	end

	// Record end: a running pattern matches if it sits at its end or at %,
	always_comb begin
		status_fin = status_n;
		if (status_n == ST_RUN)
			status_fin = fin_ok[pos_n] ? ST_MATCH : ST_FAIL;
		res.matched   = (status_fin == ST_MATCH);
		res.match_end = (status_n == ST_MATCH) ? end_n : end_off;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			run_q    <= 1'b0;
			status_q <= ST_RUN;
			end_q    <= '0;
		end else if (step) begin
			if (last) begin
				pos_q    <= '0;
				run_q    <= 1'b0;
				status_q <= ST_RUN;
				end_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				run_q    <= run_n;
				status_q <= status_n;
				end_q    <= end_n;
			end
		end
	end

endmodule

// File: sv/version_tag_pattern_matcher_top.sv
// Version tag pattern matcher, top level. Depends on vtpm_pkg and vtpm_lane.
//
// Input channel (in_valid / in_stall): one record byte per transaction, with
// last_byte marking the final byte of a record. Output channel (out_valid /
// out_stall): one transaction per record, carrying matched, pattern_index and
// end_offset. The user must write patterns and pattern_count over the cfg_we port
// only while no record is in flight; the block itself does not enforce this.
// Throughput: one byte per cycle while in_stall is low, set by the state update of
// each pattern lane between the input register and the result register.
// The result of a record is loaded into the result register as its last byte
// leaves the input register, so it passes both registers before out_valid.
// Reset clears all pattern state, the byte count, the configuration and the
// result valid flag. While the receiver stalls, bytes of the next record keep
// flowing; only a last byte waits in the input register, raising in_stall,
// until the pending result has been taken.
module version_tag_pattern_matcher_top #(
	parameter int NUM_PATTERNS  = vtpm_pkg::NUM_PATTERNS_DEF,
	parameter int PATTERN_BYTES = vtpm_pkg::PATTERN_BYTES_DEF,
	parameter int MAX_RECORD    = vtpm_pkg::MAX_RECORD_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        text_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              matched,
	output logic                              pattern_index,
	output logic [7:0]                        end_offset,
	input  logic                              cfg_we,
	input  logic [vtpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vtpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int OFFSET_CAP = (MAX_RECORD < 255) ? MAX_RECORD : 255;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       advance, step, load;
	logic [7:0] bytes_seen_q, end_off;
	logic [1:0] count_q;

	logic [vtpm_pkg::PAT_BITS-1:0] pat_w [NUM_PATTERNS];
	vtpm_pkg::lane_res_t           res [NUM_PATTERNS];

	logic       sel_matched, sel_index;
	logic [7:0] sel_end;

	// Hold a last byte only while a finished result is still waiting
	assign advance  = !(valid_s1 && last_s1 && out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;
	assign load     = step && last_s1;

	assign end_off = (bytes_seen_q < 8'(OFFSET_CAP)) ? bytes_seen_q + 8'd1 : 8'(OFFSET_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// Byte count, saturating; drop back to zero after each record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
		end else if (step) begin
			bytes_seen_q <= last_s1 ? 8'd0 : end_off;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we && cfg_index == vtpm_pkg::REG_PATTERN_COUNT) begin
			count_q <= cfg_data[1:0];
		end
	end

	for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_pat
		if (p < vtpm_pkg::NUM_REG_PATTERNS) begin : g_reg
			localparam logic [vtpm_pkg::CFG_IDX_W-1:0] LO_IDX =
				(p == 0) ? vtpm_pkg::REG_FIRST_LOW : vtpm_pkg::REG_SECOND_LOW;
			localparam logic [vtpm_pkg::CFG_IDX_W-1:0] HI_IDX =
				(p == 0) ? vtpm_pkg::REG_FIRST_HIGH : vtpm_pkg::REG_SECOND_HIGH;
			logic [vtpm_pkg::CFG_DATA_W-1:0] lo_q, hi_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					lo_q <= '0;
					hi_q <= '0;
				end else if (cfg_we) begin
					if (cfg_index == LO_IDX)
						lo_q <= cfg_data;
					if (cfg_index == HI_IDX)
						hi_q <= cfg_data;
				end
			end
			assign pat_w[p] = {hi_q, lo_q};
		end else begin : g_empty
			// No register behind this pattern: it reads as empty
			assign pat_w[p] = '0;
		end

		vtpm_lane #(
			.PATTERN_BYTES(PATTERN_BYTES)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.last      (last_s1),
			.text_byte (byte_s1),
			.end_off   (end_off),
			.pattern   (pat_w[p]),
			.res       (res[p])
		);
	end

	// First enabled pattern in order that matched
	always_comb begin
		sel_matched = 1'b0;
		sel_index   = 1'b0;
		sel_end     = '0;
		for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
			if (p < int'(count_q) && res[p].matched) begin
				sel_matched = 1'b1;
				sel_index   = p[0];
				sel_end     = res[p].match_end;
			end
		end
	end

	// Result register: load on a last byte, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			matched       <= sel_matched;
			pattern_index <= sel_index;
			end_offset    <= sel_end;
		end
	end

`ifndef SYNTHESIS
	// A match always consumed at least one byte
	a_match_has_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> end_offset != 8'd0)
		else $error("matched result with zero end_offset");

	// No match reports index zero and offset zero
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> end_offset == 8'd0 && pattern_index == 1'b0)
		else $error("unmatched result carries index or offset");

	// The byte count restarts after the last byte of a record
	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> bytes_seen_q == 8'd0 && out_valid)
		else $error("byte count not cleared after record end");
`endif

endmodule
